### design/cbm_pkg.sv
// Shared types, codes and constants of the cartridge bank mapper.
`default_nettype none
package cbm_pkg;

  typedef enum logic [2:0] {
    ActCpuRead  = 3'd0,
    ActCpuWrite = 3'd1,
    ActPpuRead  = 3'd2,
    ActPpuWrite = 3'd3,
    ActTick     = 3'd4
  } action_e;

  typedef enum logic [2:0] {
    TgtNone    = 3'd0,
    TgtOpenBus = 3'd1,
    TgtReg     = 3'd2,
    TgtPrgRam  = 3'd3,
    TgtPrgRom  = 3'd4,
    TgtChrRom  = 3'd5,
    TgtChrRam  = 3'd6,
    TgtNtRam   = 3'd7
  } target_e;

  // CPU 2K windows, address bits 15..11
  localparam logic [4:0] WinAudio = 5'h09;
  localparam logic [4:0] WinCntLo = 5'h0a;
  localparam logic [4:0] WinCntHi = 5'h0b;
  localparam logic [4:0] WinPrg0  = 5'h1c;
  localparam logic [4:0] WinPrg1  = 5'h1d;
  localparam logic [4:0] WinPrg2  = 5'h1e;

  localparam logic [14:0] CountTop     = 15'h7fff;
  localparam logic [5:0]  FixedPrgBank = 6'h3f;
  localparam logic [7:0]  ChrRamBankMin = 8'he0;

  // Bank table: entries 0..11 pattern banks, 12..14 program banks
  localparam int unsigned BankDepth  = 15;
  localparam int unsigned BankAddrW  = $clog2(BankDepth);
  localparam int unsigned BankWidth  = 8;
  localparam logic [BankAddrW-1:0] PrgBankBase = BankAddrW'(12);

  typedef struct packed {
    logic [2:0]  action;
    logic [15:0] address;
    logic [7:0]  write_value;
  } in_req_t;

  typedef struct packed {
    logic [2:0]  target;
    logic [18:0] memory_address;
    logic [7:0]  register_data;
    logic        write_strobe;
    logic [7:0]  write_byte;
    logic        irq_fire;
  } out_req_t;

  // Flop-held mapper state seen by the resolve stage
  typedef struct packed {
    logic [14:0] irq_count;
    logic        irq_enabled;
    logic [1:0]  mirroring;
    logic [1:0]  ram_enables;
    logic        chr_ram_present;
  } map_state_t;

endpackage
`default_nettype wire

### design/cbm_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module cbm_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule
`default_nettype wire

### design/cbm_bank_store.sv
// Bank table: RAM plus per-entry valid bits so unwritten entries read as zero.
`default_nettype none
module cbm_bank_store (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          we_i,
  input  wire logic [cbm_pkg::BankAddrW-1:0] waddr_i,
  input  wire logic [cbm_pkg::BankWidth-1:0] wdata_i,
  input  wire logic                          re_i,
  input  wire logic [cbm_pkg::BankAddrW-1:0] raddr_i,
  output logic      [cbm_pkg::BankWidth-1:0] rdata_o
);

  logic [cbm_pkg::BankDepth-1:0] valid_q;
  logic                          rd_valid_q;
  logic [cbm_pkg::BankWidth-1:0] ram_rdata;

  cbm_ram #(
    .Width(cbm_pkg::BankWidth),
    .Depth(cbm_pkg::BankDepth)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (we_i),
    .waddr_i(waddr_i),
    .wdata_i(wdata_i),
    .re_i   (re_i),
    .raddr_i(raddr_i),
    .rdata_o(ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      rd_valid_q <= 1'b0;
    end else begin
      if (we_i) begin
        valid_q[waddr_i] <= 1'b1;
      end
      if (re_i) begin
        rd_valid_q <= valid_q[raddr_i];
      end
    end
  end

  assign rdata_o = rd_valid_q ? ram_rdata : '0;

endmodule
`default_nettype wire

### design/cbm_resolve.sv
// Second stage: target and address translation from bank data and state.
`default_nettype none
module cbm_resolve (
  input  wire cbm_pkg::in_req_t              req_i,
  input  wire logic                          fire_i,
  input  wire logic [cbm_pkg::BankWidth-1:0] bank_i,
  input  wire cbm_pkg::map_state_t           state_i,
  output cbm_pkg::out_req_t                  rsp_o
);

  logic [15:0] a;
  logic [4:0]  win;
  logic [7:0]  d;
  logic [10:0] nt_addr;
  logic        nt_hi;
  logic        chr_ram_hit;

  assign a   = req_i.address;
  assign win = a[15:11];
  assign d   = req_i.write_value;

  // nametable bit 10 follows mirroring mode
  always_comb begin
    case (state_i.mirroring)
      2'd0:    nt_hi = 1'b0;
      2'd1:    nt_hi = a[10];
      2'd2:    nt_hi = a[11];
      default: nt_hi = 1'b1;
    endcase
    nt_addr = {nt_hi, a[9:0]};
  end

  assign chr_ram_hit = (bank_i >= cbm_pkg::ChrRamBankMin) && state_i.ram_enables[a[12]];

  always_comb begin
    rsp_o = '0;
    case (cbm_pkg::action_e'(req_i.action))
      cbm_pkg::ActCpuRead: begin
        if (win == cbm_pkg::WinAudio) begin
          rsp_o.target = cbm_pkg::TgtNone;
        end else if (win == cbm_pkg::WinCntLo) begin
          rsp_o.target        = cbm_pkg::TgtReg;
          rsp_o.register_data = state_i.irq_count[7:0];
        end else if (win == cbm_pkg::WinCntHi) begin
          rsp_o.target        = cbm_pkg::TgtReg;
          rsp_o.register_data = {state_i.irq_enabled, state_i.irq_count[14:8]};
        end else if (a[15:13] == 3'b011) begin
          rsp_o.target         = cbm_pkg::TgtPrgRam;
          rsp_o.memory_address = {6'd0, a[12:0]};
        end else if (a[15:13] == 3'b111) begin
          rsp_o.target         = cbm_pkg::TgtPrgRom;
          rsp_o.memory_address = {cbm_pkg::FixedPrgBank, a[12:0]};
        end else if (a[15]) begin
          rsp_o.target         = cbm_pkg::TgtPrgRom;
          rsp_o.memory_address = {bank_i[5:0], a[12:0]};
        end else begin
          rsp_o.target = cbm_pkg::TgtOpenBus;
        end
      end
      cbm_pkg::ActCpuWrite: begin
        if (a[15:12] < 4'h5) begin
          rsp_o.target = cbm_pkg::TgtNone;
        end else if (a[15:12] == 4'h5) begin
          rsp_o.target = cbm_pkg::TgtReg;
        end else if (!a[15]) begin
          rsp_o.target         = cbm_pkg::TgtPrgRam;
          rsp_o.memory_address = {6'd0, a[12:0]};
          rsp_o.write_strobe   = 1'b1;
          rsp_o.write_byte     = d;
        end else begin
          rsp_o.target = cbm_pkg::TgtReg;
        end
      end
      cbm_pkg::ActPpuRead, cbm_pkg::ActPpuWrite: begin
        if (a[13] || (chr_ram_hit && !state_i.chr_ram_present)) begin
          rsp_o.target         = cbm_pkg::TgtNtRam;
          rsp_o.memory_address = {8'd0, nt_addr};
          rsp_o.write_strobe   = req_i.action[0];
          rsp_o.write_byte     = req_i.action[0] ? d : 8'd0;
        end else if (chr_ram_hit) begin
          rsp_o.target         = cbm_pkg::TgtChrRam;
          rsp_o.memory_address = {6'd0, a[12:0]};
          rsp_o.write_strobe   = req_i.action[0];
          rsp_o.write_byte     = req_i.action[0] ? d : 8'd0;
        end else if (req_i.action[0]) begin
          rsp_o.target = cbm_pkg::TgtNone;
        end else begin
          rsp_o.target         = cbm_pkg::TgtChrRom;
          rsp_o.memory_address = {1'b0, bank_i, a[9:0]};
        end
      end
      cbm_pkg::ActTick: begin
        rsp_o.irq_fire = fire_i;
      end
      default: begin
        rsp_o = '0;
      end
    endcase
  end

endmodule
`default_nettype wire

### design/cartridge_bank_mapper_with_irq.sv
// Top level of the cartridge bank mapper with IRQ counter.
// One request (CPU read/write, PPU read/write or clock tick) is taken per
// cycle and yields exactly one result; sustained rate is one request
// per cycle while the output side is not stalled. The twelve pattern
// banks and three program banks live in a 15-entry bank RAM with a
// registered read. Stage 0 (at accept) issues the bank read and
// applies every state change: bank writes go to the RAM, counter, enable,
// mirroring and pattern-RAM enable writes go to flops, and a tick steps the
// counter and notes whether it just reached 0x7fff. Because each request
// updates state as it enters, the next request's bank read already sees it,
// so no forwarding is needed. Stage 1 decodes target and translated address
// from the bank read data; the result sits in an output register, and a
// new request is accepted whenever the stage-1 slot can move on. Bank
// entries read as zero until written (per-entry valid bits, no clear pass).
`default_nettype none
module cartridge_bank_mapper_with_irq (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              cfg_we_i,
  input  wire logic              cfg_wdata_i,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire cbm_pkg::in_req_t  in_req_i,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output cbm_pkg::out_req_t      out_req_o
);

  // config
  logic chr_ram_present_q;

  // flop state
  logic [14:0] count_q, count_d;
  logic        irq_en_q, irq_en_d;
  logic [1:0]  mirror_q, mirror_d;
  logic [1:0]  ram_en_q, ram_en_d;

  // bank RAM ports
  logic                          bank_we, bank_re;
  logic [cbm_pkg::BankAddrW-1:0] bank_waddr, bank_raddr;
  logic [cbm_pkg::BankWidth-1:0] bank_wdata, bank_rdata;

  // pipeline
  logic              s1_valid_q;
  cbm_pkg::in_req_t  s1_req_q;
  logic              s1_fire_q;
  logic              fire_d;
  logic              out_valid_q;
  cbm_pkg::out_req_t out_req_q;
  cbm_pkg::out_req_t rsp;
  cbm_pkg::map_state_t state;
  logic              s1_advance;
  logic              accept;

  logic [15:0] a;
  logic [4:0]  win;
  logic [7:0]  d;

  assign a   = in_req_i.address;
  assign win = a[15:11];
  assign d   = in_req_i.write_value;

  // stage 1 moves on when the output register is empty or being drained
  assign s1_advance = !out_valid_q || out_ready_i;
  assign in_ready_o = !s1_valid_q || s1_advance;
  assign accept     = in_valid_i && in_ready_o;

  // stage 0: bank read address and state updates
  always_comb begin
    count_d    = count_q;
    irq_en_d   = irq_en_q;
    mirror_d   = mirror_q;
    ram_en_d   = ram_en_q;
    fire_d     = 1'b0;
    bank_we    = 1'b0;
    bank_waddr = '0;
    bank_wdata = '0;
    bank_re    = 1'b0;
    bank_raddr = '0;
    case (cbm_pkg::action_e'(in_req_i.action))
      cbm_pkg::ActCpuRead: begin
        // switchable program window 0x8000-0xdfff
        if (a[15] && (a[14:13] != 2'b11)) begin
          bank_re    = 1'b1;
          bank_raddr = cbm_pkg::PrgBankBase + {2'b00, a[14:13]};
        end
      end
      cbm_pkg::ActCpuWrite: begin
        if (win == cbm_pkg::WinCntLo) begin
          count_d[7:0] = d;
        end else if (win == cbm_pkg::WinCntHi) begin
          count_d[14:8] = d[6:0];
          irq_en_d      = d[7];
        end else if (a[15] && (a[14:13] != 2'b11)) begin
          // pattern bank select, one per 2K window
          bank_we    = 1'b1;
          bank_waddr = a[14:11];
          bank_wdata = d;
        end else if (win == cbm_pkg::WinPrg0) begin
          bank_we    = 1'b1;
          bank_waddr = cbm_pkg::PrgBankBase;
          bank_wdata = {2'b00, d[5:0]};
          mirror_d   = d[7:6];
        end else if (win == cbm_pkg::WinPrg1) begin
          bank_we    = 1'b1;
          bank_waddr = cbm_pkg::PrgBankBase + cbm_pkg::BankAddrW'(1);
          bank_wdata = {2'b00, d[5:0]};
          ram_en_d   = d[7:6];
        end else if (win == cbm_pkg::WinPrg2) begin
          bank_we    = 1'b1;
          bank_waddr = cbm_pkg::PrgBankBase + cbm_pkg::BankAddrW'(2);
          bank_wdata = {2'b00, d[5:0]};
        end
      end
      cbm_pkg::ActPpuRead, cbm_pkg::ActPpuWrite: begin
        if (!a[13]) begin
          bank_re    = 1'b1;
          bank_raddr = {1'b0, a[12:10]};
        end
      end
      cbm_pkg::ActTick: begin
        // count up, hold at the top
        if (irq_en_q && (count_q != cbm_pkg::CountTop)) begin
          count_d = count_q + 15'd1;
          fire_d  = (count_d == cbm_pkg::CountTop);
        end
      end
      default: begin
        fire_d = 1'b0;
      end
    endcase
  end

  cbm_bank_store u_bank_store (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .we_i   (bank_we && accept),
    .waddr_i(bank_waddr),
    .wdata_i(bank_wdata),
    .re_i   (bank_re && accept),
    .raddr_i(bank_raddr),
    .rdata_o(bank_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chr_ram_present_q <= 1'b0;
      count_q           <= '0;
      irq_en_q          <= 1'b0;
      mirror_q          <= '0;
      ram_en_q          <= '0;
      s1_valid_q        <= 1'b0;
      out_valid_q       <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        chr_ram_present_q <= cfg_wdata_i;
      end
      if (accept) begin
        count_q  <= count_d;
        irq_en_q <= irq_en_d;
        mirror_q <= mirror_d;
        ram_en_q <= ram_en_d;
      end
      if (in_ready_o) begin
        s1_valid_q <= in_valid_i;
      end
      if (s1_advance) begin
        out_valid_q <= s1_valid_q;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_req_q  <= in_req_i;
      s1_fire_q <= fire_d;
    end
    if (s1_advance && s1_valid_q) begin
      out_req_q <= rsp;
    end
  end

  // stage 1: state here already includes this request's own updates,
  // which only ever touch fields that its own result does not read
  assign state = '{
    irq_count:       count_q,
    irq_enabled:     irq_en_q,
    mirroring:       mirror_q,
    ram_enables:     ram_en_q,
    chr_ram_present: chr_ram_present_q
  };

  cbm_resolve u_resolve (
    .req_i  (s1_req_q),
    .fire_i (s1_fire_q),
    .bank_i (bank_rdata),
    .state_i(state),
    .rsp_o  (rsp)
  );

  assign out_valid_o = out_valid_q;
  assign out_req_o   = out_req_q;

endmodule
`default_nettype wire

### verif/cartridge_bank_mapper_with_irq_tb.sv
// Self-checking testbench of the cartridge bank mapper against a mapper predictor.
`timescale 1ns / 1ps
module cartridge_bank_mapper_with_irq_tb;

  localparam int unsigned StallLimit    = 3000;  // cycles with no handshake at all
  localparam int unsigned HoldOffCycles = 120;   // long receiver stall, fills the pipe
  localparam int unsigned DrainCycles   = 6;     // two-stage pipe, with margin

  // Mirror of the mapper state. Every request updates it in acceptance
  // order, so the oldest queued entry is always the next result due.
  class mapper_scoreboard;
    bit                 chr_ram_present;
    bit [5:0]           prog_page [3];
    bit [7:0]           pat_page [12];
    bit [14:0]          irq_count;
    bit                 irq_enabled;
    bit [1:0]           mirroring;
    bit [1:0]           ram_enables;
    cbm_pkg::out_req_t  expected_q [$];
    int unsigned        mismatches;
    int unsigned        checked;
    int unsigned        irq_seen;

    function new();
      chr_ram_present = 1'b0;
      foreach (prog_page[i]) prog_page[i] = '0;
      foreach (pat_page[i]) pat_page[i] = '0;
      irq_count   = '0;
      irq_enabled = 1'b0;
      mirroring   = '0;
      ram_enables = '0;
      mismatches  = 0;
      checked     = 0;
      irq_seen    = 0;
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction

    // Nametable bit 10 comes from the mirroring mode
    function logic [18:0] nametable_addr(logic [13:0] a);
      logic hi;
      case (mirroring)
        2'd0:    hi = 1'b0;
        2'd1:    hi = a[10];
        2'd2:    hi = a[11];
        default: hi = 1'b1;
      endcase
      return {8'h00, hi, a[9:0]};
    endfunction

    function void note_request(cbm_pkg::in_req_t r);
      cbm_pkg::out_req_t o;
      logic [15:0]       a;
      logic [13:0]       pa;
      logic [7:0]        d;
      logic [7:0]        bank;
      o  = '0;
      a  = r.address;
      pa = r.address[13:0];
      d  = r.write_value;
      case (r.action)
        cbm_pkg::ActCpuRead: begin
          if (a[15:11] == cbm_pkg::WinAudio) begin
            o.target = cbm_pkg::TgtNone;
          end else if (a[15:11] == cbm_pkg::WinCntLo) begin
            o.target = cbm_pkg::TgtReg;
            o.register_data = irq_count[7:0];
          end else if (a[15:11] == cbm_pkg::WinCntHi) begin
            o.target = cbm_pkg::TgtReg;
            o.register_data = {irq_enabled, irq_count[14:8]};
          end else if (a >= 16'h6000 && a < 16'h8000) begin
            o.target = cbm_pkg::TgtPrgRam;
            o.memory_address = {6'd0, a[12:0]};
          end else if (a >= 16'h8000 && a < 16'he000) begin
            o.target = cbm_pkg::TgtPrgRom;
            o.memory_address = {prog_page[a[14:13]], a[12:0]};
          end else if (a >= 16'he000) begin
            o.target = cbm_pkg::TgtPrgRom;
            o.memory_address = {cbm_pkg::FixedPrgBank, a[12:0]};
          end else begin
            o.target = cbm_pkg::TgtOpenBus;
          end
        end
        cbm_pkg::ActCpuWrite: begin
          if (a < 16'h5000) begin
            o.target = cbm_pkg::TgtNone;
          end else if (a[15:11] == cbm_pkg::WinCntLo) begin
            o.target = cbm_pkg::TgtReg;
            irq_count[7:0] = d;
          end else if (a[15:11] == cbm_pkg::WinCntHi) begin
            o.target = cbm_pkg::TgtReg;
            irq_count[14:8] = d[6:0];
            irq_enabled = d[7];
          end else if (a < 16'h8000) begin
            o.target = cbm_pkg::TgtPrgRam;
            o.memory_address = {6'd0, a[12:0]};
            o.write_strobe = 1'b1;
            o.write_byte = d;
          end else if (a < 16'he000) begin
            o.target = cbm_pkg::TgtReg;
            pat_page[a[14:11]] = d;
          end else begin
            // 0xf800 is write protection: accepted, no effect
            o.target = cbm_pkg::TgtReg;
            if (a[15:11] == cbm_pkg::WinPrg0) begin
              prog_page[0] = d[5:0];
              mirroring = d[7:6];
            end else if (a[15:11] == cbm_pkg::WinPrg1) begin
              prog_page[1] = d[5:0];
              ram_enables = d[7:6];
            end else if (a[15:11] == cbm_pkg::WinPrg2) begin
              prog_page[2] = d[5:0];
            end
          end
        end
        cbm_pkg::ActPpuRead, cbm_pkg::ActPpuWrite: begin
          if (pa[13]) begin
            o.target = cbm_pkg::TgtNtRam;
            o.memory_address = nametable_addr(pa);
          end else begin
            bank = pat_page[pa[12:10]];
            if (bank >= cbm_pkg::ChrRamBankMin && ram_enables[pa[12]]) begin
              if (chr_ram_present) begin
                o.target = cbm_pkg::TgtChrRam;
                o.memory_address = {6'd0, pa[12:0]};
              end else begin
                o.target = cbm_pkg::TgtNtRam;
                o.memory_address = nametable_addr(pa);
              end
            end else if (r.action == cbm_pkg::ActPpuWrite) begin
              o.target = cbm_pkg::TgtNone;
            end else begin
              o.target = cbm_pkg::TgtChrRom;
              o.memory_address = {1'b0, bank, pa[9:0]};
            end
          end
          // a write lands only where a RAM was chosen
          if (r.action == cbm_pkg::ActPpuWrite && o.target != cbm_pkg::TgtNone) begin
            o.write_strobe = 1'b1;
            o.write_byte = d;
          end
        end
        cbm_pkg::ActTick: begin
          if (irq_enabled && irq_count != cbm_pkg::CountTop) begin
            irq_count = irq_count + 15'd1;
            o.irq_fire = (irq_count == cbm_pkg::CountTop);
          end
        end
        default: o = '0;
      endcase
      expected_q.push_back(o);
    endfunction

    function void check_result(cbm_pkg::out_req_t got);
      cbm_pkg::out_req_t want;
      if (expected_q.size() == 0) begin
        $display("%0t: result with none expected: %h", $time, got);
        mismatches++;
        return;
      end
      want = expected_q.pop_front();
      checked++;
      if (got.irq_fire) irq_seen++;
      if (got.target !== want.target) begin
        $display("%0t: target exp %0d got %0d", $time, want.target, got.target);
        mismatches++;
      end
      if (got.memory_address !== want.memory_address) begin
        $display("%0t: memory_address exp %h got %h", $time, want.memory_address,
                 got.memory_address);
        mismatches++;
      end
      if (got.register_data !== want.register_data) begin
        $display("%0t: register_data exp %h got %h", $time, want.register_data,
                 got.register_data);
        mismatches++;
      end
      if (got.write_strobe !== want.write_strobe) begin
        $display("%0t: write_strobe exp %b got %b", $time, want.write_strobe,
                 got.write_strobe);
        mismatches++;
      end
      if (got.write_byte !== want.write_byte) begin
        $display("%0t: write_byte exp %h got %h", $time, want.write_byte, got.write_byte);
        mismatches++;
      end
      if (got.irq_fire !== want.irq_fire) begin
        $display("%0t: irq_fire exp %b got %b", $time, want.irq_fire, got.irq_fire);
        mismatches++;
      end
    endfunction
  endclass

  logic              clk = 1'b0;
  logic              rst_n;
  logic              cfg_we;
  logic              cfg_wdata;
  logic              in_valid;
  logic              in_ready;
  cbm_pkg::in_req_t  in_req;
  logic              out_valid;
  logic              out_ready;
  cbm_pkg::out_req_t out_req;

  mapper_scoreboard sb;
  int unsigned      requests_sent = 0;
  int unsigned      quiet_cycles  = 0;
  bit               steady        = 1'b0;  // no random idling on either side
  bit               hold_off_req  = 1'b0;  // asks the receiver for one long stall

  cartridge_bank_mapper_with_irq dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_req_i    (in_req),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_req_o   (out_req)
  );

  // 20 ns clock
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // About 21 idle cycles in a hundred, none while steady is set
  function automatic bit take_break();
    return !steady && ($urandom_range(99) < 21);
  endfunction

  function automatic cbm_pkg::in_req_t req_of(logic [2:0] act, logic [15:0] addr,
                                              logic [7:0] data);
    cbm_pkg::in_req_t r;
    r.action      = act;
    r.address     = addr;
    r.write_value = data;
    return r;
  endfunction

  // Sender: payload changes only at the falling edge, acceptance is seen at
  // the rising edge. Random gaps go in front of the request, never after
  // valid is up.
  task automatic send_request(input cbm_pkg::in_req_t r);
    @(negedge clk);
    while (take_break()) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_req   <= r;
    do @(posedge clk); while (!in_ready);
    sb.note_request(r);
    requests_sent++;
  endtask

  // Drop valid and wait until every expected result has come back
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic write_chr_ram_present(input bit value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    sb.chr_ram_present = value;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Corner cases first: every window of the CPU map, the counter running
  // into saturation, the first and last pattern bank and every program bank
  // register, both PPU halves and the unused action codes.
  task automatic directed_requests();
    send_request(req_of(cbm_pkg::ActCpuRead,  16'h0000, 8'h00));  // open bus
    send_request(req_of(cbm_pkg::ActCpuRead,  16'h4800, 8'hff));  // audio window, ignored
    send_request(req_of(cbm_pkg::ActCpuWrite, 16'h4fff, 8'hff));  // below registers
    send_request(req_of(cbm_pkg::ActCpuWrite, 16'h5000, 8'hfd));  // counter low
    send_request(req_of(cbm_pkg::ActCpuWrite, 16'h5800, 8'hff));  // counter high + enable
    send_request(req_of(cbm_pkg::ActCpuRead,  16'h5000, 8'h00));
    send_request(req_of(cbm_pkg::ActCpuRead,  16'h5fff, 8'h00));
    send_request(req_of(cbm_pkg::ActTick,     16'h0000, 8'h00));
    send_request(req_of(cbm_pkg::ActTick,     16'hffff, 8'hff));  // reaches the top, fires
    send_request(req_of(cbm_pkg::ActTick,     16'h0000, 8'h00));  // saturated, no fire
    send_request(req_of(cbm_pkg::ActCpuWrite, 16'h8000, 8'he0));  // pattern bank 0, RAM range
    send_request(req_of(cbm_pkg::ActCpuWrite, 16'hdfff, 8'hff));  // pattern bank 11
    send_request(req_of(cbm_pkg::ActCpuWrite, 16'he000, 8'hff));  // prg 0, mirroring 3
    send_request(req_of(cbm_pkg::ActCpuWrite, 16'he800, 8'hc1));  // prg 1, both RAM enables
    send_request(req_of(cbm_pkg::ActCpuWrite, 16'hf000, 8'h2a));  // prg 2
    send_request(req_of(cbm_pkg::ActCpuWrite, 16'hf800, 8'h55));  // write protect, no effect
    send_request(req_of(cbm_pkg::ActCpuRead,  16'h8000, 8'h00));
    send_request(req_of(cbm_pkg::ActCpuRead,  16'hbfff, 8'h00));
    send_request(req_of(cbm_pkg::ActCpuRead,  16'hc000, 8'h00));
    send_request(req_of(cbm_pkg::ActCpuRead,  16'hffff, 8'h00));  // fixed last bank
    send_request(req_of(cbm_pkg::ActCpuWrite, 16'h7fff, 8'ha5));  // prg RAM write
    send_request(req_of(cbm_pkg::ActCpuRead,  16'h6000, 8'h00));
    send_request(req_of(cbm_pkg::ActPpuRead,  16'h0000, 8'h00));  // RAM bank, no chr RAM
    send_request(req_of(cbm_pkg::ActPpuWrite, 16'h0400, 8'h3c));  // chr ROM write, dropped
    send_request(req_of(cbm_pkg::ActPpuRead,  16'hffff, 8'h00));  // nametable, top bits ignored
    send_request(req_of(cbm_pkg::ActPpuWrite, 16'h2400, 8'h00));
    send_request(req_of(3'd5,                 16'h0000, 8'h00));
    send_request(req_of(3'd6,                 16'hffff, 8'h00));
    send_request(req_of(3'd7,                 16'h5000, 8'hff));
  endtask

  // Random traffic in short bursts. Counter bursts load a value near the
  // top and tick it through saturation; bank bursts set pattern banks
  // (often in the RAM range) and sometimes mode bits, then hit the PPU side.
  task automatic random_requests(input int unsigned count);
    int unsigned stop_at;
    int unsigned kind;
    int unsigned n;
    logic [7:0]  d;
    logic [2:0]  act;
    stop_at = requests_sent + count;
    while (requests_sent < stop_at) begin
      kind = $urandom_range(99);
      if (kind < 25) begin
        send_request(req_of(3'($urandom_range(7)), 16'($urandom_range(16'hffff)),
                            8'($urandom_range(255))));
      end else if (kind < 45) begin
        d = ($urandom_range(4) != 0) ? 8'($urandom_range(8'hff, 8'he0))
                                     : 8'($urandom_range(255));
        send_request(req_of(cbm_pkg::ActCpuWrite,
                            16'h5000 | 16'($urandom_range(16'h7ff)), d));
        d = ($urandom_range(3) != 0) ? 8'hff : 8'($urandom_range(255));
        send_request(req_of(cbm_pkg::ActCpuWrite,
                            16'h5800 | 16'($urandom_range(16'h7ff)), d));
        n = $urandom_range(40, 1);
        repeat (n) begin
          if ($urandom_range(9) == 0)
            send_request(req_of(cbm_pkg::ActCpuRead,
                                16'h5000 | 16'($urandom_range(16'hfff)), 8'h00));
          else
            send_request(req_of(cbm_pkg::ActTick, 16'($urandom_range(16'hffff)),
                                8'($urandom_range(255))));
        end
      end else if (kind < 70) begin
        n = $urandom_range(3, 1);
        repeat (n) begin
          d = $urandom_range(1) ? 8'($urandom_range(8'hff, 8'he0)) : 8'($urandom_range(255));
          send_request(req_of(cbm_pkg::ActCpuWrite,
                              16'h8000 + 16'($urandom_range(16'h5fff)), d));
        end
        if ($urandom_range(1))
          send_request(req_of(cbm_pkg::ActCpuWrite,
                              16'(((cbm_pkg::WinPrg0 + $urandom_range(3)) << 11) |
                                  $urandom_range(11'h7ff)),
                              8'($urandom_range(255))));
        n = $urandom_range(8, 2);
        repeat (n) begin
          act = $urandom_range(1) ? cbm_pkg::ActPpuWrite : cbm_pkg::ActPpuRead;
          send_request(req_of(act, 16'($urandom_range(16'hffff)), 8'($urandom_range(255))));
        end
      end else begin
        n = $urandom_range(8, 2);
        repeat (n) begin
          act = 3'($urandom_range(3));
          send_request(req_of(act, 16'($urandom_range(16'hffff, 16'h4000)),
                              8'($urandom_range(255))));
        end
      end
    end
  endtask

  // Receiver: ready moves at the falling edge. One long hold-off, counted
  // here, lets the pipe fill so the input side has to stall.
  initial begin
    forever begin
      @(negedge clk);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        out_ready <= 1'b0;
        repeat (HoldOffCycles - 1) @(negedge clk);
      end else begin
        out_ready <= !take_break();
      end
    end
  end

  // Result check at the rising edge
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) sb.check_result(out_req);
  end

  // Watchdog: too long without any handshake ends the run
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= StallLimit) begin
      $display("%0t: no handshake for %0d cycles, %0d results outstanding",
               $time, StallLimit, sb.pending());
      $display("end of test: mismatches");
      $finish;
    end
  end

  initial begin
    sb        = new();
    rst_n     = 1'b0;
    cfg_we    = 1'b0;
    cfg_wdata = 1'b0;
    in_valid  = 1'b0;
    in_req    = '0;
    out_ready = 1'b0;
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;

    write_chr_ram_present(1'b0);
    directed_requests();
    drain();

    // chr RAM fitted; the first stretch runs with no idling at all
    write_chr_ram_present(1'b1);
    steady = 1'b1;
    random_requests(150);
    steady = 1'b0;
    random_requests(170);
    drain();

    // no chr RAM; output held off long enough to back up the input
    write_chr_ram_present(1'b0);
    hold_off_req = 1'b1;
    random_requests(320);
    drain();

    write_chr_ram_present(1'b1);
    random_requests(290);
    drain();

    $display("Ran %0d requests over both chr RAM settings, %0d results checked,",
             requests_sent, sb.checked);
    $display("%0d IRQ firings seen, one long output stall with input backpressure.",
             sb.irq_seen);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
